// File: hdl/mid_pkg.sv
// Package for the mobile identity element decoder.
// Holds the item and result structs, phase encoding and code constants.
// No dependencies; every module of the decoder imports it.
package mid_pkg;

  // Parser phase, one-hot.
  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_LENGTH = 4'b0010,
    PH_TYPE   = 4'b0100,
    PH_VALUE  = 4'b1000
  } phase_t;

  // Result item kinds.
  localparam logic [2:0] KIND_IEI    = 3'd0;
  localparam logic [2:0] KIND_LENGTH = 3'd1;
  localparam logic [2:0] KIND_TYPE   = 3'd2;
  localparam logic [2:0] KIND_DIGITS = 3'd3;
  localparam logic [2:0] KIND_GROUP  = 3'd4;
  localparam logic [2:0] KIND_MME    = 3'd5;
  localparam logic [2:0] KIND_TMSI   = 3'd6;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_IEI       = 3'd1;
  localparam logic [2:0] ST_SHORT     = 3'd2;
  localparam logic [2:0] ST_UNKNOWN   = 3'd3;
  localparam logic [2:0] ST_BAD_SPARE = 3'd4;
  localparam logic [2:0] ST_BAD_END   = 3'd5;

  // Identity types.
  localparam logic [2:0] TYPE_IMSI = 3'd1;
  localparam logic [2:0] TYPE_IMEI = 3'd3;
  localparam logic [2:0] TYPE_GUTI = 3'd6;

  // Fixed value octet counts.
  localparam logic [7:0] GUTI_OCTETS = 8'd11;
  localparam logic [7:0] IMEI_OCTETS = 8'd8;

  // GUTI value octet positions that change the item kind.
  localparam logic [3:0] GUTI_LAST_PLMN  = 4'd3;
  localparam logic [3:0] GUTI_LAST_GROUP = 4'd5;
  localparam logic [3:0] GUTI_MME        = 4'd6;

  localparam logic [3:0] NIBBLE_FILL = 4'hf;
  localparam logic [7:0] LEN_SAT     = 8'hff;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_byte;
    logic [15:0] buffer_length;
  } in_item_t;

  typedef struct packed {
    logic [2:0] item_kind;
    logic [3:0] low_nibble;
    logic [3:0] high_nibble;
    logic [1:0] digits_valid;
    logic [2:0] identity_type;
    logic       odd_even;
    logic       last;
    logic [2:0] status;
    logic [7:0] total_octets;
    logic [3:0] digit_count;
  } result_t;

endpackage

// File: hdl/mid_in_stage.sv
// Input register of the decoder: captures one octet transfer.
// Depends on mid_pkg for the input item struct.
module mid_in_stage
  import mid_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     held_valid,
  output in_item_t held_item
);

  // The register frees up whenever its octet moves on to the parser.
  assign in_ready = !held_valid || advance;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_item;
    end
  end

endmodule

// File: hdl/mid_parser.sv
// Parser state and per-octet decode logic of the decoder.
// Depends on mid_pkg for phase encoding, codes and the result struct.
module mid_parser
  import mid_pkg::*;
#(
  parameter int MAX_IMSI_OCTETS = 8
)
(
  input  logic     clk,
  input  logic     rst,
  input  logic     step,
  input  in_item_t item,
  input  logic [7:0] expected_iei,
  output logic     res_valid,
  output result_t  res
);

  localparam logic [7:0] IMSI_MAX = 8'(MAX_IMSI_OCTETS);

  phase_t     phase, phase_next;
  logic [3:0] value_index, value_index_next;
  logic [7:0] element_length, element_length_next;
  logic [2:0] held_type, held_type_next;
  logic       held_odd_even, held_odd_even_next;
  logic [3:0] digit_tally, digit_tally_next;
  logic [1:0] header_octets, header_octets_next;

  // Decode of one octet against the current state.
  always_comb begin
    phase_t      ph;
    logic        done;
    logic        fin;
    logic [2:0]  kind;
    logic [1:0]  dv;
    logic        show_type;
    logic [2:0]  stat;
    logic [7:0]  total;
    logic [15:0] avail;
    logic [7:0]  imsi_oct;
    logic [3:0]  high;
    logic [4:0]  vpos;
    logic        even_end;

    ph                  = phase;
    value_index_next    = value_index;
    element_length_next = element_length;
    held_type_next      = held_type;
    held_odd_even_next  = held_odd_even;
    digit_tally_next    = digit_tally;
    header_octets_next  = header_octets;
    done      = 1'b0;
    fin       = 1'b0;
    kind      = KIND_IEI;
    dv        = 2'd0;
    show_type = 1'b0;
    stat      = ST_OK;
    total     = 8'd0;
    avail     = 16'd0;
    res_valid = 1'b0;
    high      = item.data_byte[7:4];
    imsi_oct  = (element_length < IMSI_MAX) ? element_length : IMSI_MAX;
    vpos      = 5'd0;
    even_end  = 1'b0;

    // A first octet restarts the element; with an identifier it ends here.
    if (item.first_byte) begin
      held_type_next     = 3'd0;
      held_odd_even_next = 1'b0;
      digit_tally_next   = 4'd0;
      value_index_next   = 4'd0;
      header_octets_next = (expected_iei != 8'd0) ? 2'd2 : 2'd1;
      avail = (item.buffer_length > {14'd0, header_octets_next}) ?
              item.buffer_length - {14'd0, header_octets_next} : 16'd0;
      element_length_next = (avail > {8'd0, LEN_SAT}) ? LEN_SAT : avail[7:0];
      ph = PH_LENGTH;
      if (expected_iei != 8'd0) begin
        done      = 1'b1;
        res_valid = 1'b1;
        kind      = KIND_IEI;
        if (item.data_byte != expected_iei) begin
          fin   = 1'b1;
          stat  = ST_IEI;
          total = 8'd1;
        end
      end
    end else if (phase == PH_IDLE) begin
      done = 1'b1;
    end

    if (!done) begin
      res_valid = 1'b1;
      unique case (ph)
        PH_LENGTH: begin
          kind = KIND_LENGTH;
          if (item.data_byte == 8'd0 || item.data_byte > element_length_next) begin
            fin   = 1'b1;
            stat  = ST_SHORT;
            total = {6'd0, header_octets_next};
          end else begin
            element_length_next = item.data_byte;
            ph = PH_TYPE;
          end
        end
        PH_TYPE: begin
          kind               = KIND_TYPE;
          show_type          = 1'b1;
          total              = {6'd0, header_octets} + 8'd1;
          held_type_next     = item.data_byte[2:0];
          held_odd_even_next = item.data_byte[3];
          value_index_next   = 4'd0;
          ph = PH_VALUE;
          if (held_type_next == TYPE_IMSI) begin
            if (imsi_oct == 8'd1) begin
              dv               = {1'b0, held_odd_even_next};
              digit_tally_next = {3'd0, held_odd_even_next};
              fin              = 1'b1;
              stat = (!held_odd_even_next && high != NIBBLE_FILL) ? ST_BAD_END : ST_OK;
            end else begin
              dv               = 2'd1;
              digit_tally_next = 4'd1;
            end
          end else if (held_type_next == TYPE_GUTI) begin
            if (high != NIBBLE_FILL) begin
              fin  = 1'b1;
              stat = ST_BAD_SPARE;
            end else if (element_length < GUTI_OCTETS) begin
              fin  = 1'b1;
              stat = ST_SHORT;
            end
          end else if (held_type_next == TYPE_IMEI) begin
            dv = 2'd1;
            if (element_length < IMEI_OCTETS) begin
              fin  = 1'b1;
              stat = ST_SHORT;
            end
          end else begin
            fin  = 1'b1;
            stat = ST_UNKNOWN;
          end
        end
        PH_VALUE: begin
          show_type        = 1'b1;
          value_index_next = value_index + 4'd1;
          vpos  = {1'b0, value_index_next} + 5'd1;
          total = {6'd0, header_octets} + {4'd0, value_index_next} + 8'd1;
          if (held_type == TYPE_IMSI) begin
            kind     = KIND_DIGITS;
            fin      = ({3'd0, vpos} >= imsi_oct);
            even_end = fin && !held_odd_even;
            dv       = even_end ? 2'd1 : 2'd2;
            digit_tally_next = digit_tally + {2'd0, dv};
            if (even_end && high != NIBBLE_FILL) begin
              stat = ST_BAD_END;
            end
          end else if (held_type == TYPE_GUTI) begin
            if (value_index_next <= GUTI_LAST_PLMN) begin
              kind = KIND_DIGITS;
              dv   = 2'd2;
            end else if (value_index_next <= GUTI_LAST_GROUP) begin
              kind = KIND_GROUP;
            end else if (value_index_next == GUTI_MME) begin
              kind = KIND_MME;
            end else begin
              kind = KIND_TMSI;
            end
            fin = ({3'd0, vpos} >= GUTI_OCTETS);
          end else begin
            kind = KIND_DIGITS;
            dv   = 2'd2;
            fin  = ({3'd0, vpos} >= IMEI_OCTETS);
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end

    phase_next = fin ? PH_IDLE : ph;

    // Assemble the result; summary fields only on the final octet.
    res.item_kind     = kind;
    res.low_nibble    = item.data_byte[3:0];
    res.high_nibble   = high;
    res.digits_valid  = dv;
    res.identity_type = show_type ? held_type_next : 3'd0;
    res.odd_even      = show_type ? held_odd_even_next : 1'b0;
    res.last          = fin;
    res.status        = fin ? stat : ST_OK;
    res.total_octets  = fin ? total : 8'd0;
    res.digit_count   = (fin && held_type_next == TYPE_IMSI) ? digit_tally_next : 4'd0;
  end

  // Parser state advances once per octet handed over.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      value_index    <= 4'd0;
      element_length <= 8'd0;
      held_type      <= 3'd0;
      held_odd_even  <= 1'b0;
      digit_tally    <= 4'd0;
      header_octets  <= 2'd0;
    end else if (step) begin
      phase          <= phase_next;
      value_index    <= value_index_next;
      element_length <= element_length_next;
      held_type      <= held_type_next;
      held_odd_even  <= held_odd_even_next;
      digit_tally    <= digit_tally_next;
      header_octets  <= header_octets_next;
    end
  end

endmodule

// File: hdl/mid_out_stage.sv
// Result register of the decoder, holding one result until its transfer.
// Depends on mid_pkg for the result struct.
module mid_out_stage
  import mid_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    held_valid,
  input  logic    res_valid,
  input  result_t res,
  output logic    advance,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  // The pipeline moves when the result register is empty or being drained.
  assign advance = !out_valid || out_ready;

  // Valid flag: octets that yield nothing leave the register empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= held_valid && res_valid;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (advance && held_valid && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// File: hdl/mobile_identity_ie_decoder.sv
// Top level of the mobile identity element decoder.
// Depends on mid_pkg, mid_in_stage, mid_parser and mid_out_stage.
//
//   Channel   Handshake               Payload
//   input     in_valid / in_ready     data_byte, first_byte, buffer_length
//   result    out_valid / out_ready   item_kind ... digit_count
//   config    cfg_write_en            cfg_write_data (expected_iei)
//
// One octet is taken per cycle while no stalled result holds the pipeline; its result reaches
// the outputs through the input register and then the result register around the parser.
// Reset is synchronous and leaves the parser idle with expected_iei at zero.
// A stalled result holds the pipeline; octets that yield no result pass silently.
module mobile_identity_ie_decoder
  import mid_pkg::*;
#(
  parameter int MAX_IMSI_OCTETS = 8
)
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [7:0]  cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        first_byte,
  input  logic [15:0] buffer_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  item_kind,
  output logic [3:0]  low_nibble,
  output logic [3:0]  high_nibble,
  output logic [1:0]  digits_valid,
  output logic [2:0]  identity_type,
  output logic        odd_even,
  output logic        last,
  output logic [2:0]  status,
  output logic [7:0]  total_octets,
  output logic [3:0]  digit_count
);

  logic [7:0] expected_iei;
  in_item_t   in_item;
  in_item_t   held_item;
  logic       held_valid;
  logic       advance;
  logic       res_valid;
  result_t    res;
  result_t    out_res;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_iei <= 8'd0;
    end else if (cfg_write_en) begin
      expected_iei <= cfg_write_data;
    end
  end

  assign in_item = {data_byte, first_byte, buffer_length};

  mid_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  mid_parser #(
    .MAX_IMSI_OCTETS (MAX_IMSI_OCTETS)
  ) u_parser (
    .clk          (clk),
    .rst          (rst),
    .step         (held_valid && advance),
    .item         (held_item),
    .expected_iei (expected_iei),
    .res_valid    (res_valid),
    .res          (res)
  );

  mid_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .held_valid (held_valid),
    .res_valid  (res_valid),
    .res        (res),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  // Result fields to ports.
  assign item_kind     = out_res.item_kind;
  assign low_nibble    = out_res.low_nibble;
  assign high_nibble   = out_res.high_nibble;
  assign digits_valid  = out_res.digits_valid;
  assign identity_type = out_res.identity_type;
  assign odd_even      = out_res.odd_even;
  assign last          = out_res.last;
  assign status        = out_res.status;
  assign total_octets  = out_res.total_octets;
  assign digit_count   = out_res.digit_count;

endmodule

// File: bench/tb.sv
// Self-checking bench for mobile_identity_ie_decoder: octet-serial stimulus with random gaps
// and stalls, checked against a cycle-free decoder model kept alongside the driver.
// Depends on mid_pkg and the decoder RTL only.
`timescale 1ns / 100ps

module tb;
  import mid_pkg::*;

  localparam int IMSI_CAP    = 8;
  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [7:0]  cfg_write_data = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        first_byte = 1'b0;
  logic [15:0] buffer_length = 16'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  item_kind;
  logic [3:0]  low_nibble;
  logic [3:0]  high_nibble;
  logic [1:0]  digits_valid;
  logic [2:0]  identity_type;
  logic        odd_even;
  logic        last;
  logic [2:0]  status;
  logic [7:0]  total_octets;
  logic [3:0]  digit_count;

  mobile_identity_ie_decoder #(.MAX_IMSI_OCTETS(IMSI_CAP)) dut (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .first_byte(first_byte), .buffer_length(buffer_length),
    .out_valid(out_valid), .out_ready(out_ready),
    .item_kind(item_kind), .low_nibble(low_nibble), .high_nibble(high_nibble),
    .digits_valid(digits_valid), .identity_type(identity_type), .odd_even(odd_even),
    .last(last), .status(status), .total_octets(total_octets), .digit_count(digit_count)
  );

  // Octets waiting to be driven and decoded results waiting to be seen.
  in_item_t octet_q[$];
  result_t  expected_results[$];
  in_item_t cur_item;

  int  octets_queued = 0;
  int  octets_taken = 0;
  int  results_checked = 0;
  int  errors = 0;
  int  settings_used = 0;
  int  status_tally [8];
  int  gap_left = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  int  next_hold_at = 300;
  int  cycle_count = 0;
  bit  calm = 1'b0;

  // Decoder model state and its copy of the expected identifier octet.
  phase_t      ph = PH_IDLE;
  logic [3:0]  val_idx = 4'd0;
  logic [7:0]  elem_len = 8'd0;
  logic [2:0]  id_type = 3'd0;
  logic        id_odd = 1'b0;
  logic [3:0]  digits_so_far = 4'd0;
  logic [1:0]  hdr_octets = 2'd0;
  logic [7:0]  iei_setting = 8'd0;

  initial begin
    forever #5 clk = ~clk;
  end

  // Builds one result from the held element state; a closing result returns the parser to idle.
  function automatic result_t form_result(logic [2:0] kind, logic [7:0] b, logic [1:0] dv,
                                          logic show, logic fin, logic [2:0] st,
                                          logic [7:0] total);
    result_t r;
    r.item_kind     = kind;
    r.low_nibble    = b[3:0];
    r.high_nibble   = b[7:4];
    r.digits_valid  = dv;
    r.identity_type = show ? id_type : 3'd0;
    r.odd_even      = show ? id_odd : 1'b0;
    r.last          = fin;
    r.status        = fin ? st : ST_OK;
    r.total_octets  = fin ? total : 8'd0;
    r.digit_count   = (fin && id_type == TYPE_IMSI) ? digits_so_far : 4'd0;
    if (fin) ph = PH_IDLE;
    return r;
  endfunction

  // Advances the model by one octet; returns 1 when the octet yields a result.
  function automatic bit decode_octet(input in_item_t it, output result_t r);
    logic [7:0]  b;
    logic [16:0] avail;
    logic [7:0]  total;
    logic [1:0]  dv;
    logic [2:0]  kind;
    logic        fin;
    int          imsi_n;
    b = it.data_byte;
    r = '0;
    if (it.first_byte) begin
      id_type = 3'd0;
      id_odd = 1'b0;
      digits_so_far = 4'd0;
      val_idx = 4'd0;
      hdr_octets = (iei_setting != 8'd0) ? 2'd2 : 2'd1;
      avail = ({1'b0, it.buffer_length} > {15'd0, hdr_octets}) ?
              {1'b0, it.buffer_length} - {15'd0, hdr_octets} : 17'd0;
      elem_len = (avail > 17'd255) ? LEN_SAT : avail[7:0];
      ph = PH_LENGTH;
      if (iei_setting != 8'd0) begin
        r = form_result(KIND_IEI, b, 2'd0, 1'b0, b != iei_setting, ST_IEI, 8'd1);
        return 1'b1;
      end
    end else if (ph == PH_IDLE) begin
      return 1'b0;
    end
    imsi_n = (elem_len < IMSI_CAP) ? int'(elem_len) : IMSI_CAP;
    case (ph)
      PH_LENGTH: begin
        if (b == 8'd0 || b > elem_len) begin
          r = form_result(KIND_LENGTH, b, 2'd0, 1'b0, 1'b1, ST_SHORT, {6'd0, hdr_octets});
        end else begin
          elem_len = b;
          ph = PH_TYPE;
          r = form_result(KIND_LENGTH, b, 2'd0, 1'b0, 1'b0, ST_OK, 8'd0);
        end
      end
      PH_TYPE: begin
        total = {6'd0, hdr_octets} + 8'd1;
        id_type = b[2:0];
        id_odd = b[3];
        val_idx = 4'd0;
        ph = PH_VALUE;
        imsi_n = (elem_len < IMSI_CAP) ? int'(elem_len) : IMSI_CAP;
        if (id_type == TYPE_IMSI) begin
          if (imsi_n == 1) begin
            // A one-octet IMSI: the type octet carries the only digit, if any.
            dv = id_odd ? 2'd1 : 2'd0;
            digits_so_far = {2'd0, dv};
            r = form_result(KIND_TYPE, b, dv, 1'b1, 1'b1,
                            (!id_odd && b[7:4] != NIBBLE_FILL) ? ST_BAD_END : ST_OK, total);
          end else begin
            digits_so_far = 4'd1;
            r = form_result(KIND_TYPE, b, 2'd1, 1'b1, 1'b0, ST_OK, 8'd0);
          end
        end else if (id_type == TYPE_GUTI) begin
          if (b[7:4] != NIBBLE_FILL)
            r = form_result(KIND_TYPE, b, 2'd0, 1'b1, 1'b1, ST_BAD_SPARE, total);
          else if (elem_len < GUTI_OCTETS)
            r = form_result(KIND_TYPE, b, 2'd0, 1'b1, 1'b1, ST_SHORT, total);
          else
            r = form_result(KIND_TYPE, b, 2'd0, 1'b1, 1'b0, ST_OK, 8'd0);
        end else if (id_type == TYPE_IMEI) begin
          r = form_result(KIND_TYPE, b, 2'd1, 1'b1, elem_len < IMEI_OCTETS, ST_SHORT, total);
        end else begin
          r = form_result(KIND_TYPE, b, 2'd0, 1'b1, 1'b1, ST_UNKNOWN, total);
        end
      end
      default: begin
        val_idx = val_idx + 4'd1;
        total = {6'd0, hdr_octets} + {4'd0, val_idx} + 8'd1;
        if (id_type == TYPE_IMSI) begin
          // The last octet of an even count holds one digit and the filler nibble.
          fin = (int'(val_idx) + 1 >= imsi_n);
          dv = (fin && !id_odd) ? 2'd1 : 2'd2;
          digits_so_far = digits_so_far + {2'd0, dv};
          r = form_result(KIND_DIGITS, b, dv, 1'b1, fin,
                          (fin && !id_odd && b[7:4] != NIBBLE_FILL) ? ST_BAD_END : ST_OK, total);
        end else if (id_type == TYPE_GUTI) begin
          dv = 2'd0;
          if (val_idx <= GUTI_LAST_PLMN) begin
            kind = KIND_DIGITS;
            dv = 2'd2;
          end else if (val_idx <= GUTI_LAST_GROUP) begin
            kind = KIND_GROUP;
          end else if (val_idx == GUTI_MME) begin
            kind = KIND_MME;
          end else begin
            kind = KIND_TMSI;
          end
          r = form_result(kind, b, dv, 1'b1, {4'd0, val_idx} + 8'd1 >= GUTI_OCTETS, ST_OK,
                          total);
        end else begin
          r = form_result(KIND_DIGITS, b, 2'd2, 1'b1,
                          {4'd0, val_idx} + 8'd1 >= IMEI_OCTETS, ST_OK, total);
        end
      end
    endcase
    return 1'b1;
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf({"kind %0d hi/lo %h/%h digits %0d type %0d oe %0d ",
                      "last %0d status %0d total %0d count %0d"},
                     r.item_kind, r.high_nibble, r.low_nibble, r.digits_valid, r.identity_type,
                     r.odd_even, r.last, r.status, r.total_octets, r.digit_count);
  endfunction

  // Mostly back-to-back, sometimes a short pause, rarely a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_octet(logic [7:0] b, logic f, logic [15:0] bl);
    in_item_t it;
    it.data_byte = b;
    it.first_byte = f;
    it.buffer_length = bl;
    octet_q.push_back(it);
    octets_queued++;
  endtask

  // One element, mostly well formed, with random content and occasional damage.
  task automatic gen_element();
    int          roll;
    int          len;
    int          hdr;
    int          plan_n;
    int          nsent;
    logic [2:0]  ty;
    logic        oe;
    logic [3:0]  hi;
    logic [15:0] blen;
    logic [7:0]  lb;
    logic [7:0]  b;
    hdr = (iei_setting != 8'd0) ? 2 : 1;
    roll = $urandom_range(0, 99);
    if (roll < 35) begin
      ty = TYPE_IMSI;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 255) : $urandom_range(1, 9);
    end else if (roll < 57) begin
      ty = TYPE_GUTI;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : int'(GUTI_OCTETS);
    end else if (roll < 80) begin
      ty = TYPE_IMEI;
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : int'(IMEI_OCTETS);
    end else begin
      ty = 3'($urandom_range(0, 7));
      while (ty == TYPE_IMSI || ty == TYPE_IMEI || ty == TYPE_GUTI)
        ty = 3'($urandom_range(0, 7));
      len = $urandom_range(1, 20);
    end
    oe = 1'($urandom_range(0, 1));
    hi = 4'($urandom_range(0, 15));
    if ((ty == TYPE_GUTI || (ty == TYPE_IMSI && len == 1 && !oe)) && $urandom_range(0, 9) != 0)
      hi = NIBBLE_FILL;

    // Buffer length: usually enough, sometimes too little, sometimes far more.
    roll = $urandom_range(0, 99);
    if (roll < 80) blen = 16'(hdr + len + $urandom_range(0, 3));
    else if (roll < 88) blen = 16'($urandom_range(0, hdr + len - 1));
    else if (roll < 96) blen = 16'($urandom_range(256, 65535));
    else blen = 16'hffff;

    lb = len[7:0];
    if ($urandom_range(0, 29) == 0) lb = 8'd0;
    if (hdr == 2) begin
      push_octet(($urandom_range(0, 9) == 0) ? 8'($urandom) : iei_setting, 1'b1, blen);
      push_octet(lb, 1'b0, 16'($urandom));
    end else begin
      push_octet(lb, 1'b1, blen);
    end
    push_octet({hi, oe, ty}, 1'b0, 16'($urandom));

    if (ty == TYPE_IMSI) plan_n = ((len < IMSI_CAP) ? len : IMSI_CAP) - 1;
    else if (ty == TYPE_GUTI) plan_n = int'(GUTI_OCTETS) - 1;
    else if (ty == TYPE_IMEI) plan_n = int'(IMEI_OCTETS) - 1;
    else plan_n = 0;
    roll = $urandom_range(0, 99);
    if (roll < 80) nsent = plan_n;
    else if (roll < 88) nsent = $urandom_range(0, plan_n);
    else nsent = plan_n + $urandom_range(1, 3);

    for (int i = 1; i <= nsent; i++) begin
      b = 8'($urandom);
      if (ty == TYPE_IMSI && i == plan_n && !oe && $urandom_range(0, 9) != 0)
        b[7:4] = NIBBLE_FILL;
      push_octet(b, 1'b0, 16'($urandom));
    end
    // Stray octets between elements.
    if ($urandom_range(0, 19) == 0) begin
      repeat ($urandom_range(1, 3)) push_octet(8'($urandom), 1'b0, 16'($urandom));
    end
  endtask

  // Waits until every octet is taken and every result seen, then lets the pipeline empty.
  task automatic settle();
    while (octet_q.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_iei(logic [7:0] v);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= v;
    iei_setting = v;
    settings_used++;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
  endtask

  // Driver: offers queued octets, keeps each one steady until its transfer.
  always @(posedge clk) begin : driver
    result_t  want;
    in_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        octets_taken++;
        if (decode_octet(cur_item, want)) expected_results.push_back(want);
      end
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (octet_q.size() != 0) begin
          nxt = octet_q.pop_front();
          cur_item = nxt;
          data_byte <= nxt.data_byte;
          first_byte <= nxt.first_byte;
          buffer_length <= nxt.buffer_length;
          in_valid <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off while the sender still has plenty to offer.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      next_hold_at <= 300;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (octets_taken >= next_hold_at && octet_q.size() > 40) begin
      hold_left <= 400;
      next_hold_at <= next_hold_at + 600;
    end
  end

  // Monitor: checks each result transfer against the oldest expectation.
  always @(posedge clk) begin : monitor
    result_t got;
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {item_kind, low_nibble, high_nibble, digits_valid, identity_type, odd_even,
               last, status, total_octets, digit_count};
        results_checked++;
        if (got.last) status_tally[got.status]++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("%0t: result with none expected: %s", $time, fmt_result(got));
        end else begin
          want = expected_results.pop_front();
          if (got.item_kind !== want.item_kind || got.low_nibble !== want.low_nibble ||
              got.high_nibble !== want.high_nibble || got.digits_valid !== want.digits_valid ||
              got.identity_type !== want.identity_type || got.odd_even !== want.odd_even ||
              got.last !== want.last || got.status !== want.status ||
              got.total_octets !== want.total_octets ||
              got.digit_count !== want.digit_count) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch, expected %s", $time, fmt_result(want));
              $display("%0t:           actual   %s", $time, fmt_result(got));
            end
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= (hold_left == 0);
        stall_left <= pick_gap();
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Stimulus: directed elements first, then random phases under several identifier settings.
  initial begin
    logic [7:0] iei_plan [6];
    int         made;
    iei_plan[0] = 8'hff;
    iei_plan[1] = 8'h00;
    iei_plan[2] = 8'h01;
    iei_plan[3] = 8'($urandom_range(1, 254));
    iei_plan[4] = 8'h00;
    iei_plan[5] = 8'($urandom);

    // Without an identifier octet: stray octet, one-octet odd IMSI, zero and excess length,
    // unknown type, GUTI bad spare, short GUTI, short IMEI, even IMSI with a bad end mark,
    // restart inside an element, and a one-octet even IMSI with a saturated buffer length.
    push_octet(8'h5a, 1'b0, 16'h0000);
    push_octet(8'h01, 1'b1, 16'd2);     push_octet(8'h19, 1'b0, 16'hffff);
    push_octet(8'h00, 1'b1, 16'd5);
    push_octet(8'h09, 1'b1, 16'd3);
    push_octet(8'h01, 1'b1, 16'd2);     push_octet(8'h02, 1'b0, 16'h0000);
    push_octet(8'h0b, 1'b1, 16'd12);    push_octet(8'h06, 1'b0, 16'h0000);
    push_octet(8'h05, 1'b1, 16'd6);     push_octet(8'hf6, 1'b0, 16'h0000);
    push_octet(8'h03, 1'b1, 16'd4);     push_octet(8'hf3, 1'b0, 16'h0000);
    push_octet(8'h02, 1'b1, 16'd3);     push_octet(8'h21, 1'b0, 16'h0000);
    push_octet(8'h43, 1'b0, 16'h0000);
    push_octet(8'h03, 1'b1, 16'd4);     push_octet(8'h09, 1'b0, 16'h0000);
    push_octet(8'h01, 1'b1, 16'hffff);  push_octet(8'hf1, 1'b0, 16'hffff);
    push_octet(8'hff, 1'b0, 16'hffff);

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    settle();

    // With an identifier octet: a wrong one, then a good one-octet IMSI.
    write_iei(iei_plan[0]);
    push_octet(8'h00, 1'b1, 16'd0);
    push_octet(8'hff, 1'b1, 16'd3);     push_octet(8'h01, 1'b0, 16'h0000);
    push_octet(8'h19, 1'b0, 16'h0000);

    for (int p = 0; p < 6; p++) begin
      settle();
      write_iei(iei_plan[p]);
      calm = (p == 2);
      made = octets_queued;
      while (octets_queued - made < 290) gen_element();
    end
    settle();
    repeat (10) @(posedge clk);

    $display("Sent %0d octets and checked %0d results over %0d identifier settings.",
             octets_taken, results_checked, settings_used + 1);
    $display({"Closing results: ok %0d, iei %0d, short %0d, unknown %0d, ",
              "spare %0d, end mark %0d."},
             status_tally[ST_OK], status_tally[ST_IEI], status_tally[ST_SHORT],
             status_tally[ST_UNKNOWN], status_tally[ST_BAD_SPARE], status_tally[ST_BAD_END]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/mid_pkg.sv
hdl/mid_in_stage.sv
hdl/mid_parser.sv
hdl/mid_out_stage.sv
hdl/mobile_identity_ie_decoder.sv
bench/tb.sv
